[hdl/assert_macros.svh]
// Assertion macros used by the checker file of the FNV-1a seal/verify block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge, skipped while reset is high.
`define CHK_HOLDS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("checker: property violated");

// Check a property at every clock edge, reset included.
`define CHK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("checker: property violated");

`endif

[hdl/fnvs_pkg.sv]
// Shared types and constants for the FNV-1a footer seal/verify block.
// No dependencies; imported by the front, queue, back and top modules.
package fnvs_pkg;

  localparam logic [31:0] FNV_PRIME   = 32'd16777619;
  localparam logic [31:0] FNV_BASIS   = 32'd2166136261;
  localparam logic [31:0] COMMIT_WORD = 32'h4B4F3357;
  localparam int unsigned HOLD_DEPTH  = 8;

  // Input action codes
  localparam logic [1:0] ACT_DATA     = 2'd0;
  localparam logic [1:0] ACT_DATA_END = 2'd1;
  localparam logic [1:0] ACT_END      = 2'd2;
  localparam logic [1:0] ACT_END_ALT  = 2'd3;

  // Result kinds
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_BAD_WORD = 2'd2;
  localparam logic [1:0] ST_MISMATCH = 2'd3;

  typedef logic [3:0] step_t;

  // Result sequence of one sealed command
  localparam step_t STEP_DATA = 4'd0;
  localparam step_t STEP_H0   = 4'd1;
  localparam step_t STEP_H1   = 4'd2;
  localparam step_t STEP_H2   = 4'd3;
  localparam step_t STEP_H3   = 4'd4;
  localparam step_t STEP_C0   = 4'd5;
  localparam step_t STEP_C1   = 4'd6;
  localparam step_t STEP_C2   = 4'd7;
  localparam step_t STEP_LAST = 4'd8;

  // One classified command from front to back
  typedef struct packed {
    logic        verdict;   // verify end: emit one verdict
    logic        has_byte;  // seal: pass data first
    logic        ends;      // seal: append footer
    logic        is_short;  // verify: fewer than eight bytes held
    logic [7:0]  data;
    logic [31:0] hash;      // hash after this item
    logic [63:0] held;      // held bytes, oldest in the low byte
  } cmd_t;

endpackage

[hdl/fnvs_front.sv]
// Front end: accepts input words, runs the FNV-1a hash and hold-back window,
// and pushes classified commands. Depends on fnvs_pkg.
module fnvs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                accept,
  input  logic [1:0]          action,
  input  logic [7:0]          data_byte,
  output logic                push,
  output fnvs_pkg::cmd_t      push_cmd
);
  import fnvs_pkg::*;

  logic        mode;
  logic [31:0] hash;
  logic [31:0] hash_next;
  logic [3:0]  count;
  logic [3:0]  count_next;
  logic [7:0]  held      [HOLD_DEPTH];
  logic [7:0]  held_next [HOLD_DEPTH];
  logic        has_byte;
  logic        ends;
  logic        full_win;
  logic [7:0]  mul_in;
  logic [31:0] hash_step;
  logic [63:0] held_flat;

  always_comb begin
    has_byte  = (action == ACT_DATA) || (action == ACT_DATA_END);
    ends      = (action != ACT_DATA);
    full_win  = (count == 4'(HOLD_DEPTH));
    // verify with a full window hashes the oldest held byte
    mul_in    = (mode && full_win) ? held[0] : data_byte;
    hash_step = (hash ^ {24'd0, mul_in}) * FNV_PRIME;

    hash_next  = hash;
    count_next = count;
    held_next  = held;
    if (has_byte) begin
      if (!mode) begin
        hash_next = hash_step;
      end else if (full_win) begin
        hash_next = hash_step;
        for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
          held_next[i] = held[i + 1];
        end
        held_next[HOLD_DEPTH - 1] = data_byte;
      end else begin
        held_next[count[2:0]] = data_byte;
        count_next            = count + 4'd1;
      end
    end

    for (int i = 0; i < HOLD_DEPTH; i++) begin
      held_flat[8 * i +: 8] = held_next[i];
    end

    push              = accept && (!mode || ends);
    push_cmd.verdict  = mode;
    push_cmd.has_byte = has_byte;
    push_cmd.ends     = ends;
    push_cmd.is_short = (count_next != 4'(HOLD_DEPTH));
    push_cmd.data     = data_byte;
    push_cmd.hash     = hash_next;
    push_cmd.held     = held_flat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= 1'b0;
      hash  <= FNV_BASIS;
      count <= 4'd0;
    end else if (cfg_we) begin
      mode  <= cfg_wdata;
      hash  <= FNV_BASIS;
      count <= 4'd0;
    end else if (accept) begin
      if (ends) begin
        hash  <= FNV_BASIS;
        count <= 4'd0;
      end else begin
        hash  <= hash_next;
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= held_next;
    end
  end

endmodule

[hdl/fnvs_queue.sv]
// Small flop-based command queue between front and back.
// Depends on fnvs_pkg for the command type.
module fnvs_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fnvs_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output fnvs_pkg::cmd_t      head,
  output logic                full,
  output logic                empty
);
  import fnvs_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

[hdl/fnvs_back.sv]
// Back end: expands commands into result words (bytes, footer, verdict)
// into a registered output stage. Depends on fnvs_pkg.
module fnvs_back (
  input  logic                clk,
  input  logic                rst,
  input  fnvs_pkg::cmd_t      head,
  input  logic                empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_kind,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic [1:0]          out_status
);
  import fnvs_pkg::*;

  cmd_t        cur;
  logic        busy;
  step_t       step;
  cmd_t        cmd_sel;
  step_t       step_sel;
  logic        fire;
  logic        done;
  logic        res_kind;
  logic [7:0]  res_byte;
  logic        res_last;
  logic [1:0]  res_status;

  function automatic logic [7:0] footer_byte(input logic [31:0] h, input step_t s);
    logic [7:0] b;
    case (s)
      STEP_H0:   b = h[7:0];
      STEP_H1:   b = h[15:8];
      STEP_H2:   b = h[23:16];
      STEP_H3:   b = h[31:24];
      STEP_C0:   b = COMMIT_WORD[7:0];
      STEP_C1:   b = COMMIT_WORD[15:8];
      STEP_C2:   b = COMMIT_WORD[23:16];
      STEP_LAST: b = COMMIT_WORD[31:24];
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

  always_comb begin
    cmd_sel  = busy ? cur : head;
    step_sel = busy ? step : (head.has_byte ? STEP_DATA : STEP_H0);
    fire     = (!out_valid || out_ready) && (busy || !empty);
    done     = cmd_sel.verdict || !cmd_sel.ends || (step_sel == STEP_LAST);
    pop      = fire && !busy;

    if (cmd_sel.verdict) begin
      res_kind = KIND_VERDICT;
      res_byte = 8'h00;
      res_last = 1'b1;
      if (cmd_sel.is_short) begin
        res_status = ST_SHORT;
      end else if (cmd_sel.held[63:32] != COMMIT_WORD) begin
        res_status = ST_BAD_WORD;
      end else if (cmd_sel.held[31:0] != cmd_sel.hash) begin
        res_status = ST_MISMATCH;
      end else begin
        res_status = ST_OK;
      end
    end else begin
      res_kind   = KIND_BYTE;
      res_byte   = (step_sel == STEP_DATA) ? cmd_sel.data
                                           : footer_byte(cmd_sel.hash, step_sel);
      res_last   = (step_sel == STEP_LAST);
      res_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
      busy      <= !done;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_kind   <= res_kind;
      out_byte   <= res_byte;
      out_last   <= res_last;
      out_status <= res_status;
      step       <= step_t'(step_sel + 4'd1);
      cur        <= cmd_sel;
    end
  end

endmodule

[hdl/fnv1a_footer_seal_verify_core.sv]
// Top level of the FNV-1a footer seal/verify block: front, queue and back.
// Depends on fnvs_pkg, fnvs_front, fnvs_queue and fnvs_back.
//
//   channel   direction  handshake          payload
//   s_*       in         tvalid/tready      tuser = action, tdata = data_byte
//   m_*       out        tvalid/tready      tuser = kind, tdata = out_byte/status,
//                                           tlast = out_last
//   cfg_*     in         write enable only  cfg_wdata = mode
//
// Cycles: the front takes one input word per clock while the queue has room;
// the FNV multiply by the prime, looped on the hash register, sets that rate.
// The back emits one result word per clock while the queue and m_tready allow:
// a sealed data byte gives one word, a sealed end eight footer words, a verify
// end one verdict. A result passes the queue and output register to reach m_*.
// Reset (rst, synchronous) empties the queue and output, sets seal mode and
// the hash basis. Output stalls back up into the queue and then s_tready.
module fnv1a_footer_seal_verify_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_wdata,     // mode: 0 seal, 1 verify
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,       // [7:0] data_byte
  input  logic [1:0]  s_tuser,       // [1:0] action
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,       // [7:0] out_byte, [9:8] status, rest zero
  output logic [0:0]  m_tuser,       // [0] kind
  output logic        m_tlast        // out_last
);
  import fnvs_pkg::*;

  logic       accept;
  logic       push;
  cmd_t       push_cmd;
  logic       pop;
  cmd_t       head;
  logic       full;
  logic       empty;
  logic       out_kind;
  logic [7:0] out_byte;
  logic [1:0] out_status;

  // Take a word whenever the queue has room; verify data bytes push nothing
  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  fnvs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .action    (s_tuser),
    .data_byte (s_tdata),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  fnvs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  fnvs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (out_kind),
    .out_byte   (out_byte),
    .out_last   (m_tlast),
    .out_status (out_status)
  );

  // Pack the result word, zero-fill to whole bytes
  assign m_tdata = {6'd0, out_status, out_byte};
  assign m_tuser = out_kind;

endmodule

[hdl/fnvs_checker.sv]
// Port-level checker for the FNV-1a seal/verify top level, bound to it below.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module fnvs_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        m_tlast
);

  // Output stage is empty right after reset
  `CHK_ALWAYS(a_rst_empty, clk, rst |=> !m_tvalid)

  // A stalled result holds
  `CHK_HOLDS(a_hold, clk, rst,
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))

  // A verdict closes its stream and carries no byte
  `CHK_HOLDS(a_verdict, clk, rst,
    (m_tvalid && m_tuser[0]) |-> (m_tlast && (m_tdata[7:0] == 8'h00)))

  // A byte result has no status; its last one is the top commit-word byte
  `CHK_HOLDS(a_seal_last, clk, rst,
    (m_tvalid && !m_tuser[0]) |->
      ((m_tdata[15:8] == 8'h00) && (!m_tlast || (m_tdata[7:0] == 8'h4B))))

endmodule

bind fnv1a_footer_seal_verify_core fnvs_checker u_fnvs_checker (
  .clk       (clk),
  .rst       (rst),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .m_tlast   (m_tlast)
);
